>>> rtl/core/rgb_median3x3_filter_unit_assert.svh
// Assertion macros shared by the median filter modules.
// RMF_ASSERT checks a property outside reset.
// RMF_ASSERT_AFTER_RESET checks a property on the cycle after a reset cycle.
`ifndef RGB_MEDIAN3X3_FILTER_UNIT_ASSERT_SVH
`define RGB_MEDIAN3X3_FILTER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define RMF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define RMF_ASSERT_AFTER_RESET(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) !rstn |=> prop) \
    else $error("reset assertion failed");
`else
`define RMF_ASSERT(lbl, clk, rstn, prop)
`define RMF_ASSERT_AFTER_RESET(lbl, clk, rstn, prop)
`endif
`endif

>>> rtl/core/rmf_pkg.sv
`default_nettype none
package rmf_pkg;

  localparam int ChanBits       = 8;
  localparam int NumChan        = 3;
  localparam int CoordBits      = 8;
  localparam int CfgBits        = 9;
  localparam int MinDim         = 3;
  localparam int MaxRows        = 256;
  localparam int WinRows        = 3;
  localparam int WinCols        = 3;
  localparam int QueueDepth     = 4;
  localparam int QueueAddrBits  = 2;
  localparam int QueueCountBits = 3;

  typedef logic [ChanBits-1:0] chan_t;
  // Channel 0 is red, 1 green, 2 blue.
  typedef chan_t [NumChan-1:0] pix_t;
  // Row 0 is the oldest line, row 2 the incoming one.
  typedef pix_t [WinRows-1:0] column_t;
  // Column 2 is the newest.
  typedef column_t [WinCols-1:0] window_t;

  typedef struct packed {
    logic                 emit;
    logic                 last;
    logic [CoordBits-1:0] row;
    logic [CoordBits-1:0] col;
  } meta_t;

  typedef enum logic [0:0] {
    CfgFrameWidth  = 1'b0,
    CfgFrameHeight = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    chan_t lo;
    chan_t mid;
    chan_t hi;
  } trio_t;

  function automatic trio_t sort3(input chan_t a, input chan_t b, input chan_t c);
    chan_t x;
    chan_t y;
    chan_t z;
    chan_t t;
    trio_t r;
    x = a;
    y = b;
    z = c;
    if (x > y) begin
      t = x; x = y; y = t;
    end
    if (y > z) begin
      t = y; y = z; z = t;
    end
    if (x > y) begin
      t = x; x = y; y = t;
    end
    r.lo  = x;
    r.mid = y;
    r.hi  = z;
    return r;
  endfunction

  function automatic chan_t max3(input chan_t a, input chan_t b, input chan_t c);
    chan_t m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic chan_t min3(input chan_t a, input chan_t b, input chan_t c);
    chan_t m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic chan_t med3(input chan_t a, input chan_t b, input chan_t c);
    chan_t lo;
    chan_t hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    hi = (hi < c) ? hi : c;
    return (lo > hi) ? lo : hi;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/rmf_queue.sv
`default_nettype none
`include "rgb_median3x3_filter_unit_assert.svh"
module rmf_queue #(
  parameter int DATA_BITS = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire logic [DATA_BITS-1:0] push_data,
  input  wire logic                 pop,
  output logic                      full,
  output logic                      nonempty,
  output logic [DATA_BITS-1:0]      head_data
);

  logic [DATA_BITS-1:0]                    slot_r [rmf_pkg::QueueDepth];
  logic [rmf_pkg::QueueAddrBits-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [rmf_pkg::QueueAddrBits-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [rmf_pkg::QueueCountBits-1:0]      count_r, count_nxt;

  localparam logic [rmf_pkg::QueueCountBits-1:0] CountFull =
    rmf_pkg::QueueCountBits'(rmf_pkg::QueueDepth);
  localparam logic [rmf_pkg::QueueCountBits-1:0] CountOne =
    rmf_pkg::QueueCountBits'(1);
  localparam logic [rmf_pkg::QueueAddrBits-1:0] PtrOne =
    rmf_pkg::QueueAddrBits'(1);

  assign full      = (count_r == CountFull);
  assign nonempty  = (count_r != '0);
  assign head_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PtrOne : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PtrOne : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CountOne;
    end else if (pop && !push) begin
      count_nxt = count_r - CountOne;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  `RMF_ASSERT(a_no_pop_empty, clk, rst_n, pop |-> count_r != '0)
  `RMF_ASSERT(a_no_push_full, clk, rst_n, push |-> count_r != CountFull)
  `RMF_ASSERT(a_count_up, clk, rst_n, push && !pop |=> count_r == $past(count_r) + CountOne)

endmodule
`default_nettype wire

>>> rtl/core/rmf_front.sv
`default_nettype none
`include "rgb_median3x3_filter_unit_assert.svh"
module rmf_front #(
  parameter int MAX_WIDTH = 256,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [0:0]                    cfg_index,
  input  wire logic [rmf_pkg::CfgBits-1:0]   cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          q_full,
  output logic                               q_push,
  output logic [AW-1:0]                      q_addr,
  output rmf_pkg::meta_t                     q_meta
);

  localparam int ResetWidth = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
  localparam logic [AW-1:0] ColLastReset = AW'(ResetWidth - 1);
  localparam logic [rmf_pkg::CoordBits-1:0] RowLastReset =
    rmf_pkg::CoordBits'(rmf_pkg::MaxRows - 1);

  logic [AW-1:0]                  col_r, col_nxt;
  logic [AW-1:0]                  col_last_r, col_last_nxt;
  logic [rmf_pkg::CoordBits-1:0]  row_r, row_nxt;
  logic [rmf_pkg::CoordBits-1:0]  row_last_r, row_last_nxt;
  logic [AW-1:0]                  width_last;
  logic [rmf_pkg::CoordBits-1:0]  height_last;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;
  assign q_addr   = col_r;

  // Each request is tagged with where its window centre lies and whether it closes the frame.
  always_comb begin
    q_meta.emit = (row_r >= rmf_pkg::CoordBits'(2)) && (col_r >= AW'(2));
    q_meta.last = (row_r == row_last_r) && (col_r == col_last_r);
    q_meta.row  = row_r - rmf_pkg::CoordBits'(1);
    q_meta.col  = rmf_pkg::CoordBits'(col_r - AW'(1));
  end

  // Register writes are stored as the clamped index of the last column or row.
  always_comb begin
    if (cfg_data < rmf_pkg::CfgBits'(rmf_pkg::MinDim)) begin
      width_last = AW'(rmf_pkg::MinDim - 1);
    end else if (int'(cfg_data) > MAX_WIDTH) begin
      width_last = AW'(MAX_WIDTH - 1);
    end else begin
      width_last = AW'(cfg_data - rmf_pkg::CfgBits'(1));
    end
    if (cfg_data < rmf_pkg::CfgBits'(rmf_pkg::MinDim)) begin
      height_last = rmf_pkg::CoordBits'(rmf_pkg::MinDim - 1);
    end else if (int'(cfg_data) > rmf_pkg::MaxRows) begin
      height_last = RowLastReset;
    end else begin
      height_last = rmf_pkg::CoordBits'(cfg_data - rmf_pkg::CfgBits'(1));
    end
  end

  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    col_last_nxt = col_last_r;
    row_last_nxt = row_last_r;
    if (cfg_we) begin
      col_nxt = '0;
      row_nxt = '0;
      unique case (rmf_pkg::cfg_reg_t'(cfg_index))
        rmf_pkg::CfgFrameWidth:  col_last_nxt = width_last;
        rmf_pkg::CfgFrameHeight: row_last_nxt = height_last;
      endcase
    end else if (q_push) begin
      if (col_r == col_last_r) begin
        col_nxt = '0;
        row_nxt = (row_r == row_last_r) ? '0 : row_r + rmf_pkg::CoordBits'(1);
      end else begin
        col_nxt = col_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      col_last_r <= ColLastReset;
      row_last_r <= RowLastReset;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      col_last_r <= col_last_nxt;
      row_last_r <= row_last_nxt;
    end
  end

  `RMF_ASSERT(a_col_in_frame, clk, rst_n, col_r <= col_last_r)
  `RMF_ASSERT_AFTER_RESET(a_reset_origin, clk, rst_n, col_r == '0 && row_r == '0)

endmodule
`default_nettype wire

>>> rtl/core/rmf_back.sv
`default_nettype none
`include "rgb_median3x3_filter_unit_assert.svh"
module rmf_back #(
  parameter int MAX_WIDTH = 256,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  restart,
  input  wire logic                  q_valid,
  input  wire rmf_pkg::pix_t         q_pix,
  input  wire logic [AW-1:0]         q_addr,
  input  wire rmf_pkg::meta_t        q_meta,
  output logic                       q_pop,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output rmf_pkg::pix_t              out_med,
  output rmf_pkg::meta_t             out_meta
);

  logic en;

  rmf_pkg::pix_t  mem_a [MAX_WIDTH];
  rmf_pkg::pix_t  mem_b [MAX_WIDTH];
  rmf_pkg::pix_t  rd_a_r, rd_b_r;

  logic           s1_valid_r;
  rmf_pkg::pix_t  s1_pix_r;
  logic [AW-1:0]  s1_addr_r;
  rmf_pkg::meta_t s1_meta_r;
  logic           wr_en;

  rmf_pkg::window_t win_r, win_nxt;

  logic           s2_valid_r;
  rmf_pkg::meta_t s2_meta_r;

  rmf_pkg::trio_t srt     [rmf_pkg::WinCols][rmf_pkg::NumChan];
  rmf_pkg::trio_t s3_srt_r [rmf_pkg::WinCols][rmf_pkg::NumChan];
  logic           s3_valid_r;
  rmf_pkg::meta_t s3_meta_r;

  rmf_pkg::pix_t  s4_lo, s4_mid, s4_hi;
  rmf_pkg::pix_t  s4_lo_r, s4_mid_r, s4_hi_r;
  logic           s4_valid_r;
  rmf_pkg::meta_t s4_meta_r;

  rmf_pkg::pix_t  med;
  logic           out_valid_r;
  rmf_pkg::pix_t  out_med_r;
  rmf_pkg::meta_t out_meta_r;

  // The whole pipeline moves together; it holds only while a finished result waits.
  assign en        = !out_valid_r || out_ready;
  assign q_pop     = en && q_valid;
  assign wr_en     = en && s1_valid_r;
  assign out_valid = out_valid_r;
  assign out_med   = out_med_r;
  assign out_meta  = out_meta_r;

  // Line stores: the line above moves to the store for two lines above.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_a[s1_addr_r] <= s1_pix_r;
    end
    if (q_pop) begin
      rd_a_r <= mem_a[q_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_b[s1_addr_r] <= rd_a_r;
    end
    if (q_pop) begin
      rd_b_r <= mem_b[q_addr];
    end
  end

  always_comb begin
    win_nxt       = win_r;
    win_nxt[0]    = win_r[1];
    win_nxt[1]    = win_r[2];
    win_nxt[2][0] = rd_b_r;
    win_nxt[2][1] = rd_a_r;
    win_nxt[2][2] = s1_pix_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      win_r <= '0;
    end else if (wr_en) begin
      win_r <= win_nxt;
    end
  end

  always_comb begin
    for (int k = 0; k < rmf_pkg::WinCols; k++) begin
      for (int ch = 0; ch < rmf_pkg::NumChan; ch++) begin
        srt[k][ch] = rmf_pkg::sort3(win_r[k][0][ch], win_r[k][1][ch], win_r[k][2][ch]);
      end
    end
  end

  // Median of nine: the largest column minimum, the median of column medians
  // and the smallest column maximum, then the median of those three.
  always_comb begin
    for (int ch = 0; ch < rmf_pkg::NumChan; ch++) begin
      s4_lo[ch]  = rmf_pkg::max3(s3_srt_r[0][ch].lo, s3_srt_r[1][ch].lo,
                                 s3_srt_r[2][ch].lo);
      s4_mid[ch] = rmf_pkg::med3(s3_srt_r[0][ch].mid, s3_srt_r[1][ch].mid,
                                 s3_srt_r[2][ch].mid);
      s4_hi[ch]  = rmf_pkg::min3(s3_srt_r[0][ch].hi, s3_srt_r[1][ch].hi,
                                 s3_srt_r[2][ch].hi);
      med[ch]    = rmf_pkg::med3(s4_lo_r[ch], s4_mid_r[ch], s4_hi_r[ch]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r  <= q_pop;
      s2_valid_r  <= s1_valid_r && s1_meta_r.emit;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      out_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_pix_r  <= q_pix;
      s1_addr_r <= q_addr;
      s1_meta_r <= q_meta;
    end
    if (en) begin
      s2_meta_r  <= s1_meta_r;
      s3_srt_r   <= srt;
      s3_meta_r  <= s2_meta_r;
      s4_lo_r    <= s4_lo;
      s4_mid_r   <= s4_mid;
      s4_hi_r    <= s4_hi;
      s4_meta_r  <= s3_meta_r;
      out_med_r  <= med;
      out_meta_r <= s4_meta_r;
    end
  end

  `RMF_ASSERT(a_win_hold, clk, rst_n, !en && !restart |=> $stable(win_r))
  `RMF_ASSERT(a_no_border_out, clk, rst_n, out_valid_r |-> out_meta_r.row != '0 && out_meta_r.col != '0)
  `RMF_ASSERT_AFTER_RESET(a_reset_empty, clk, rst_n, !out_valid_r && !s1_valid_r)

endmodule
`default_nettype wire

>>> rtl/core/rgb_median3x3_filter_unit.sv
// From the queue, requests pass the input, window, sort, merge and output registers.
// Throughput: one pixel per cycle, sustained while out_ready stays high; a four-entry
// queue lets the input side keep taking pixels while the output is held.
// Reset (synchronous, rst_n low): counters, window and queue clear; width and height
// return to MAX_WIDTH (at most 256) and 256; the line stores keep their contents and need no clearing pass.
`default_nettype none
module rgb_median3x3_filter_unit #(
  parameter int MAX_WIDTH = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [0:0]                    cfg_index,
  input  wire logic [rmf_pkg::CfgBits-1:0]   cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [rmf_pkg::ChanBits-1:0]  in_red,
  input  wire logic [rmf_pkg::ChanBits-1:0]  in_green,
  input  wire logic [rmf_pkg::ChanBits-1:0]  in_blue,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [rmf_pkg::ChanBits-1:0]       out_med_red,
  output logic [rmf_pkg::ChanBits-1:0]       out_med_green,
  output logic [rmf_pkg::ChanBits-1:0]       out_med_blue,
  output logic [rmf_pkg::CoordBits-1:0]      out_center_row,
  output logic [rmf_pkg::CoordBits-1:0]      out_center_col,
  output logic                               out_frame_last
);

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int QBits = AW + $bits(rmf_pkg::meta_t) + $bits(rmf_pkg::pix_t);

  logic              q_full, q_push, q_pop, q_nonempty;
  logic [AW-1:0]     push_addr, head_addr;
  rmf_pkg::meta_t    push_meta, head_meta;
  rmf_pkg::pix_t     push_pix, head_pix;
  logic [QBits-1:0]  head_data;
  rmf_pkg::pix_t     med;
  rmf_pkg::meta_t    res_meta;

  always_comb begin
    push_pix[0] = in_red;
    push_pix[1] = in_green;
    push_pix[2] = in_blue;
  end

  rmf_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_addr    (push_addr),
    .q_meta    (push_meta)
  );

  rmf_queue #(
    .DATA_BITS (QBits)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({push_addr, push_meta, push_pix}),
    .pop       (q_pop),
    .full      (q_full),
    .nonempty  (q_nonempty),
    .head_data (head_data)
  );

  assign {head_addr, head_meta, head_pix} = head_data;

  rmf_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .restart   (cfg_we),
    .q_valid   (q_nonempty),
    .q_pix     (head_pix),
    .q_addr    (head_addr),
    .q_meta    (head_meta),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_med   (med),
    .out_meta  (res_meta)
  );

  assign out_med_red    = med[0];
  assign out_med_green  = med[1];
  assign out_med_blue   = med[2];
  assign out_center_row = res_meta.row;
  assign out_center_col = res_meta.col;
  assign out_frame_last = res_meta.last;

endmodule
`default_nettype wire

>>> dv/tb_rgb_median3x3_filter_unit.sv
`timescale 1ns / 1ps
module tb_rgb_median3x3_filter_unit;

  localparam int FrameMax    = 256;
  localparam int DrainCycles = 12;
  localparam int HoldCycles  = 80;
  localparam int MaxReports  = 30;
  localparam int SmallBudget = 180;
  localparam int TallItems   = 60;

  typedef struct packed {
    rmf_pkg::chan_t                red;
    rmf_pkg::chan_t                green;
    rmf_pkg::chan_t                blue;
    logic [rmf_pkg::CoordBits-1:0] row;
    logic [rmf_pkg::CoordBits-1:0] col;
    logic                          last;
  } median_result_t;

  class median_scoreboard;
    logic [rmf_pkg::CfgBits-1:0] width_reg;
    logic [rmf_pkg::CfgBits-1:0] height_reg;
    rmf_pkg::pix_t               line_above[FrameMax];
    rmf_pkg::pix_t               line_two_above[FrameMax];
    rmf_pkg::pix_t               win[3][3];
    int unsigned                 row_pos;
    int unsigned                 col_pos;
    median_result_t              pending[$];
    int unsigned                 errors;
    int unsigned                 checked;

    function new();
      width_reg  = FrameMax;
      height_reg = FrameMax;
      foreach (line_above[i]) begin
        line_above[i]     = '0;
        line_two_above[i] = '0;
      end
      restart_frame();
      errors  = 0;
      checked = 0;
    endfunction

    function void restart_frame();
      row_pos = 0;
      col_pos = 0;
      foreach (win[r, c]) win[r][c] = '0;
    endfunction

    function int unsigned frame_w();
      if (width_reg < rmf_pkg::MinDim) return rmf_pkg::MinDim;
      if (width_reg > FrameMax) return FrameMax;
      return width_reg;
    endfunction

    function int unsigned frame_h();
      if (height_reg < rmf_pkg::MinDim) return rmf_pkg::MinDim;
      if (height_reg > rmf_pkg::MaxRows) return rmf_pkg::MaxRows;
      return height_reg;
    endfunction

    // Any register write starts a fresh frame; the line stores survive.
    function void write_reg(rmf_pkg::cfg_reg_t idx, logic [rmf_pkg::CfgBits-1:0] val);
      if (idx == rmf_pkg::CfgFrameWidth) width_reg = val;
      else height_reg = val;
      restart_frame();
    endfunction

    function rmf_pkg::chan_t median_of_nine(rmf_pkg::chan_t vals[9]);
      rmf_pkg::chan_t s[9];
      rmf_pkg::chan_t v;
      int             j;
      s = vals;
      for (int i = 1; i < 9; i++) begin
        v = s[i];
        j = i - 1;
        while (j >= 0 && s[j] > v) begin
          s[j + 1] = s[j];
          j--;
        end
        s[j + 1] = v;
      end
      return s[4];
    endfunction

    function void note_pixel(rmf_pkg::pix_t px);
      int unsigned    w;
      int unsigned    h;
      rmf_pkg::chan_t vals[9];
      rmf_pkg::pix_t  med;
      median_result_t res;
      w = frame_w();
      h = frame_h();
      if (col_pos >= w) col_pos = 0;
      if (row_pos >= h) row_pos = 0;
      for (int r = 0; r < 3; r++) begin
        win[r][0] = win[r][1];
        win[r][1] = win[r][2];
      end
      win[0][2] = line_two_above[col_pos];
      win[1][2] = line_above[col_pos];
      win[2][2] = px;
      line_two_above[col_pos] = line_above[col_pos];
      line_above[col_pos]     = px;
      if (row_pos >= 2 && col_pos >= 2) begin
        for (int ch = 0; ch < rmf_pkg::NumChan; ch++) begin
          for (int k = 0; k < 9; k++) vals[k] = win[k / 3][k % 3][ch];
          med[ch] = median_of_nine(vals);
        end
        res.red   = med[0];
        res.green = med[1];
        res.blue  = med[2];
        res.row   = rmf_pkg::CoordBits'(row_pos - 1);
        res.col   = rmf_pkg::CoordBits'(col_pos - 1);
        res.last  = (row_pos == h - 1) && (col_pos == w - 1);
        pending.push_back(res);
      end
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= h) row_pos = 0;
      end
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= MaxReports) $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task check_result(median_result_t got);
      median_result_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected result at row %0d col %0d", got.row, got.col));
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.red !== want.red)
        report_mismatch($sformatf("med_red got %0d, expected %0d (row %0d col %0d)",
                                  got.red, want.red, want.row, want.col));
      if (got.green !== want.green)
        report_mismatch($sformatf("med_green got %0d, expected %0d (row %0d col %0d)",
                                  got.green, want.green, want.row, want.col));
      if (got.blue !== want.blue)
        report_mismatch($sformatf("med_blue got %0d, expected %0d (row %0d col %0d)",
                                  got.blue, want.blue, want.row, want.col));
      if (got.row !== want.row)
        report_mismatch($sformatf("center_row got %0d, expected %0d", got.row, want.row));
      if (got.col !== want.col)
        report_mismatch($sformatf("center_col got %0d, expected %0d", got.col, want.col));
      if (got.last !== want.last)
        report_mismatch($sformatf("frame_last got %0b, expected %0b (row %0d col %0d)",
                                  got.last, want.last, want.row, want.col));
    endtask
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [0:0]                    cfg_index;
  logic [rmf_pkg::CfgBits-1:0]   cfg_data;
  logic                          in_valid;
  logic                          in_ready;
  logic [rmf_pkg::ChanBits-1:0]  in_red;
  logic [rmf_pkg::ChanBits-1:0]  in_green;
  logic [rmf_pkg::ChanBits-1:0]  in_blue;
  logic                          out_valid;
  logic                          out_ready;
  logic [rmf_pkg::ChanBits-1:0]  out_med_red;
  logic [rmf_pkg::ChanBits-1:0]  out_med_green;
  logic [rmf_pkg::ChanBits-1:0]  out_med_blue;
  logic [rmf_pkg::CoordBits-1:0] out_center_row;
  logic [rmf_pkg::CoordBits-1:0] out_center_col;
  logic                          out_frame_last;

  median_scoreboard board;
  bit               sender_idle;
  bit               receiver_idle;
  rmf_pkg::chan_t   band_base;
  int unsigned      pixels_sent;
  int unsigned      results_taken;
  int unsigned      phases_run;

  rgb_median3x3_filter_unit u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_med_red   (out_med_red),
    .out_med_green (out_med_green),
    .out_med_blue  (out_med_blue),
    .out_center_row(out_center_row),
    .out_center_col(out_center_col),
    .out_frame_last(out_frame_last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic write_regs(input bit do_w, input logic [rmf_pkg::CfgBits-1:0] w_val,
                            input bit do_h, input logic [rmf_pkg::CfgBits-1:0] h_val);
    if (do_w) begin
      cfg_we    <= 1'b1;
      cfg_index <= rmf_pkg::CfgFrameWidth;
      cfg_data  <= w_val;
      @(posedge clk);
      board.write_reg(rmf_pkg::CfgFrameWidth, w_val);
    end
    if (do_h) begin
      cfg_we    <= 1'b1;
      cfg_index <= rmf_pkg::CfgFrameHeight;
      cfg_data  <= h_val;
      @(posedge clk);
      board.write_reg(rmf_pkg::CfgFrameHeight, h_val);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_pixel(input rmf_pkg::pix_t px);
    int unsigned gap;
    gap = sender_idle ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_red   <= px[0];
    in_green <= px[1];
    in_blue  <= px[2];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_pixel(px);
    pixels_sent++;
  endtask

  // Mostly uniform values, with saturated values and a narrow band to force ties.
  function automatic rmf_pkg::pix_t random_pixel();
    rmf_pkg::pix_t px;
    int unsigned   sel;
    for (int ch = 0; ch < rmf_pkg::NumChan; ch++) begin
      sel = $urandom_range(0, 9);
      if (sel < 6) px[ch] = rmf_pkg::chan_t'($urandom_range(0, 255));
      else if (sel < 8) px[ch] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      else px[ch] = rmf_pkg::chan_t'(band_base + $urandom_range(0, 3));
    end
    return px;
  endfunction

  task automatic send_random(input int unsigned n);
    sender_idle = ($urandom_range(0, 3) != 0);
    band_base   = rmf_pkg::chan_t'($urandom_range(0, 255));
    repeat (n) send_pixel(random_pixel());
  endtask

  // The sender holds back until every request in flight has produced its result.
  task automatic wait_for_idle();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    phases_run++;
  endtask

  initial begin
    out_ready     <= 1'b0;
    results_taken = 0;
    receiver_idle = 1'b1;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      int unsigned    gap;
      median_result_t got;
      gap = receiver_idle ? $urandom_range(0, 4) : 0;
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got.red   = out_med_red;
      got.green = out_med_green;
      got.blue  = out_med_blue;
      got.row   = out_center_row;
      got.col   = out_center_col;
      got.last  = out_frame_last;
      board.check_result(got);
      results_taken++;
      if (results_taken % 64 == 0) receiver_idle = ($urandom_range(0, 2) != 0);
      // Long hold-offs stall the pipeline and fill the queue so that the input side stalls.
      if (results_taken == 30 || results_taken == 200 || results_taken == 500) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
    end
  end

  initial begin
    rmf_pkg::chan_t              ramp[6];
    rmf_pkg::pix_t               px;
    int unsigned                 small_items;
    int unsigned                 n;
    int unsigned                 pick;
    bit                          do_w;
    bit                          do_h;
    logic [rmf_pkg::CfgBits-1:0] w_val;
    logic [rmf_pkg::CfgBits-1:0] h_val;

    ramp        = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'hFE};
    board       = new();
    pixels_sent = 0;
    phases_run  = 0;
    small_items = 0;
    sender_idle = 1'b1;
    band_base   = '0;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= rmf_pkg::CfgFrameWidth;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    in_red    <= '0;
    in_green  <= '0;
    in_blue   <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: width below range clamps to three, height stays at its reset value.
    // An all-zero window, an all-saturated window, then alternating bit patterns.
    write_regs(1'b1, 9'd0, 1'b0, '0);
    for (int i = 0; i < 24; i++) begin
      for (int ch = 0; ch < rmf_pkg::NumChan; ch++) begin
        if (i < 9) px[ch] = 8'h00;
        else if (i < 18) px[ch] = 8'hFF;
        else px[ch] = ramp[(i + 2 * ch) % 6];
      end
      send_pixel(px);
    end
    wait_for_idle();

    // Widest frame, three rows, with the first pixels of the next frame.
    write_regs(1'b1, 9'd511, 1'b1, 9'd2);
    send_random(board.frame_w() * board.frame_h() + 5);
    wait_for_idle();

    // Height above range, three columns; the frame is left part way and the next
    // write starts a new one.
    write_regs(1'b1, 9'd1, 1'b1, 9'd300);
    send_random(TallItems);
    wait_for_idle();

    while (small_items < SmallBudget) begin
      pick  = $urandom_range(0, 3);
      do_w  = (pick != 1);
      do_h  = (pick != 0);
      w_val = rmf_pkg::CfgBits'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 2)
                                                            : $urandom_range(3, 12));
      h_val = rmf_pkg::CfgBits'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 2)
                                                            : $urandom_range(3, 8));
      write_regs(do_w, w_val, do_h, h_val);
      n = board.frame_w() * board.frame_h() * $urandom_range(1, 3);
      // Some phases stop part way through a frame before the next write restarts it.
      if ($urandom_range(0, 2) == 0)
        n += $urandom_range(0, board.frame_w() * board.frame_h() - 1);
      if (n > SmallBudget - small_items) n = SmallBudget - small_items;
      send_random(n);
      small_items += n;
      wait_for_idle();
    end

    if (board.pending.size() != 0)
      board.report_mismatch($sformatf("%0d expected results never arrived",
                                      board.pending.size()));
    $display("Sent %0d pixels over %0d phases: clamped widths and heights, a full frame",
             pixels_sent, phases_run);
    $display("at the widest line, stalls on both sides; %0d medians checked, %0d mismatches.",
             board.checked, board.errors);
    if (board.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d results still outstanding.", board.pending.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
